@@ src/ebpc_pkg.sv @@
// ebpc_pkg: types and constants for the exclusive button press classifier
// no dependencies; imported by exclusive_button_press_classifier_top
`default_nettype none
package ebpc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_ACTIVE   = 2'd2,
    PH_WAIT     = 2'd3
  } phase_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd2;

  localparam logic [3:0]  RST_BUTTON_COUNT = 4'd8;
  localparam logic [7:0]  RST_DEBOUNCE     = 8'd2;
  localparam logic [15:0] RST_LONG_PRESS   = 16'd100;

  // scan width of the pressed field and the button limit of this build
  localparam int          SCAN_W      = 8;
  localparam logic [3:0]  NUM_BUTTONS = 4'd8;
  localparam logic [3:0]  NO_BUTTON   = 4'd8;
  localparam logic [15:0] HELD_MAX    = 16'hFFFF;

endpackage
`default_nettype wire

@@ src/exclusive_button_press_classifier_top.sv @@
// exclusive_button_press_classifier_top: debounce/short-long press machine with event queue
// depends on ebpc_pkg
`default_nettype none
// One item per clock cycle, sustained while out_ready is not held low. Each accepted beat is either a scan tick
// (mode 0) that advances the idle/debounce/active/wait-release machine on the
// lowest-numbered pressed button, or a read (mode 1) that pops one event from
// a QUEUE_SLOTS-entry queue (holding at most QUEUE_SLOTS-1 events). The whole
// update is one registered pass into a single output register, and a new beat
// is taken whenever the output register is empty or is being drained in the
// same cycle. A tick that finds the queue full
// loses the event and reports event_dropped. Configuration writes are taken
// at any time but should only be issued while the block is idle.
module exclusive_button_press_classifier_top #(
  parameter int QUEUE_SLOTS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ebpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ebpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_mode,
  input  wire logic [7:0]                      in_pressed,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_event_valid,
  output logic [2:0]                           out_event_button,
  output logic                                 out_event_long,
  output logic                                 out_event_dropped,
  output logic [1:0]                           out_machine_state
);
  import ebpc_pkg::*;

  localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);

  logic [3:0]  button_count_r;
  logic [7:0]  debounce_r;
  logic [15:0] long_press_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  locked_r, locked_nxt;
  logic [15:0] held_r, held_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [3:0]  queue_mem [QUEUE_SLOTS];

  logic        out_valid_r, pop_r, dropped_r;
  logic [1:0]  state_r;
  logic [3:0]  ev_r;

  logic        accept, is_tick, is_read;
  logic [3:0]  scan_lim;
  logic [8:0]  scan_mask_w;
  logic [7:0]  levels;
  logic        lock_held;
  logic        any_low;
  logic [2:0]  first_low;
  logic [15:0] held_inc;
  logic        release_ev, is_long;
  logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
  logic        q_full, q_empty, push_ok, pop_ok;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_tick  = accept && !in_mode;
  assign is_read  = accept && in_mode;

  // buttons scanned
  always_comb begin
    scan_lim = button_count_r;
    if (scan_lim > 4'(SCAN_W)) scan_lim = 4'(SCAN_W);
    if (scan_lim > NUM_BUTTONS) scan_lim = NUM_BUTTONS;
    scan_mask_w = (9'd1 << scan_lim) - 9'd1;
    levels      = in_pressed & scan_mask_w[7:0];
  end

  assign lock_held = !locked_r[3] && levels[locked_r[2:0]];

  always_comb begin
    any_low   = 1'b0;
    first_low = 3'd0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (levels[i]) begin
        any_low   = 1'b1;
        first_low = 3'(i);
      end
    end
  end

  assign held_inc   = held_r + 16'd1;
  assign is_long    = held_r >= long_press_r;
  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
  assign q_full     = wr_ptr_inc == rd_ptr_r;
  assign q_empty    = wr_ptr_r == rd_ptr_r;
  assign release_ev = is_tick && (phase_r == PH_ACTIVE) && !lock_held;
  assign push_ok    = release_ev && !q_full;
  assign pop_ok     = is_read && !q_empty;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_tick) begin
      unique case (phase_r)
        PH_IDLE:     if (any_low) phase_nxt = PH_DEBOUNCE;
        PH_DEBOUNCE: begin
          if (!lock_held) phase_nxt = PH_IDLE;
          else if (held_inc >= {8'd0, debounce_r}) phase_nxt = PH_ACTIVE;
        end
        PH_ACTIVE:   if (!lock_held) phase_nxt = PH_WAIT;
        PH_WAIT:     if (levels == '0) phase_nxt = PH_IDLE;
        default:     phase_nxt = phase_r;
      endcase
    end
  end

  // datapath next values
  always_comb begin
    locked_nxt = locked_r;
    held_nxt   = held_r;
    wr_ptr_nxt = push_ok ? wr_ptr_inc : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_inc : rd_ptr_r;
    if (is_tick) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (any_low) begin
            locked_nxt = {1'b0, first_low};
            held_nxt   = '0;
          end
        end
        PH_DEBOUNCE: begin
          if (lock_held) begin
            held_nxt = (held_inc >= {8'd0, debounce_r}) ? 16'd0 : held_inc;
          end
        end
        PH_ACTIVE: begin
          if (lock_held && held_r != HELD_MAX) held_nxt = held_inc;
        end
        PH_WAIT: begin
          if (levels == '0) locked_nxt = NO_BUTTON;
        end
        default: locked_nxt = locked_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_count_r <= RST_BUTTON_COUNT;
      debounce_r     <= RST_DEBOUNCE;
      long_press_r   <= RST_LONG_PRESS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUTTON_COUNT: button_count_r <= cfg_wdata[3:0];
        CFG_DEBOUNCE:     debounce_r     <= cfg_wdata[7:0];
        CFG_LONG_PRESS:   long_press_r   <= cfg_wdata[15:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      locked_r    <= NO_BUTTON;
      held_r      <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
      pop_r       <= 1'b0;
      dropped_r   <= 1'b0;
      state_r     <= PH_IDLE;
    end else begin
      phase_r  <= phase_nxt;
      locked_r <= locked_nxt;
      held_r   <= held_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
        pop_r       <= pop_ok;
        dropped_r   <= release_ev && q_full;
        state_r     <= phase_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // event queue, registered read into the output beat
  always_ff @(posedge clk) begin
    if (push_ok) queue_mem[wr_ptr_r] <= {is_long, locked_r[2:0]};
    if (is_read) ev_r <= queue_mem[rd_ptr_r];
  end

  assign out_valid         = out_valid_r;
  assign out_event_valid   = pop_r;
  assign out_event_button  = pop_r ? ev_r[2:0] : 3'd0;
  assign out_event_long    = pop_r && ev_r[3];
  assign out_event_dropped = dropped_r;
  assign out_machine_state = state_r;

endmodule
`default_nettype wire
